[sv/tlvsp_pkg.sv]
// Package for the TLV stream parser: word types, result kinds, status codes.
// Used by tlv_stream_parser_top; depends on nothing else.
package tlvsp_pkg;

  localparam int unsigned MAX_TAG_BYTES = 4;
  localparam int unsigned MAX_LEN_BYTES = 2;

  // Output queue depth; a power of two so that the pointers wrap on their own.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TAG_LONG  = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

  localparam logic [7:0] TAG_MORE_MASK = 8'h1F;
  localparam logic [7:0] HIGH_BIT      = 8'h80;
  localparam logic [7:0] LOW_SEVEN     = 8'h7F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] tag_value;
    logic [15:0] value_length;
    logic [7:0]  value_byte;
    logic        item_end;
    logic [1:0]  parse_status;
    logic [14:0] item_count;
    logic        last_result;
  } out_word_t;

endpackage

[sv/tlv_stream_parser_top.sv]
// Top level of the TLV stream parser: byte-wise BER-TLV decode and output queue.
// Depends on tlvsp_pkg.
//
// Channel   Direction  Word        Handshake
// byte      in         in_word_t   byte_valid / byte_stall
// result    out        out_word_t  result_valid / result_stall
//
// One byte is decoded per cycle while byte_stall is low. Each accepted byte
// updates the parser state and writes zero, one or two result words into a
// four-entry output queue. A byte is taken only while the queue has two free
// entries, so a buffer-end byte that also closes a header or carries a value
// byte gives two words, popped one at a time. The rst input is synchronous and
// clears the parser state and the queue. Result-side stalls fill the queue past
// two entries and then raise byte_stall; no word is lost or repeated.
module tlv_stream_parser_top (
  input  logic                 clk,
  input  logic                 rst,
  input  tlvsp_pkg::in_word_t  byte_word,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  output tlvsp_pkg::out_word_t result,
  output logic                 result_valid,
  input  logic                 result_stall
);
  import tlvsp_pkg::*;

  typedef enum logic [2:0] {
    PH_TAG_FIRST,
    PH_TAG_MORE,
    PH_LEN_FIRST,
    PH_LEN_MORE,
    PH_VALUE,
    PH_STOPPED
  } phase_t;

  localparam logic [14:0] COUNT_MAX = '1;

  // Parser state.
  phase_t      phase, phase_next;
  logic [31:0] tag_accum, tag_accum_next;
  logic [2:0]  tag_bytes_seen, tag_bytes_seen_next;
  logic [15:0] length_accum, length_accum_next;
  logic [1:0]  length_bytes_left, length_bytes_left_next;
  logic [15:0] value_bytes_left, value_bytes_left_next;
  logic [14:0] items_parsed, items_parsed_next;
  logic [1:0]  stop_status, stop_status_next;

  // Output queue.
  out_word_t         queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  logic        accept, pop;
  out_word_t   item_word, done_word, first_word, second_word;
  logic        has_item;
  logic [1:0]  n_words;
  logic [6:0]  len_count;
  logic [1:0]  done_status;
  logic [15:0] header_len;

  assign byte_stall   = (count > (QPTR_W + 1)'(QDEPTH - 2));
  assign accept       = byte_valid && !byte_stall;
  assign result_valid = (count != '0);
  assign pop          = result_valid && !result_stall;
  assign result       = queue[rd_ptr];

  assign len_count = byte_word.data_byte[6:0] & LOW_SEVEN[6:0];

  always_comb begin
    phase_next             = phase;
    tag_accum_next         = tag_accum;
    tag_bytes_seen_next    = tag_bytes_seen;
    length_accum_next      = length_accum;
    length_bytes_left_next = length_bytes_left;
    value_bytes_left_next  = value_bytes_left;
    items_parsed_next      = items_parsed;
    stop_status_next       = stop_status;
    item_word              = '0;
    has_item               = 1'b0;
    header_len             = '0;

    unique case (phase)
      PH_TAG_FIRST: begin
        tag_accum_next      = {24'd0, byte_word.data_byte};
        tag_bytes_seen_next = 3'd1;
        phase_next = ((byte_word.data_byte & TAG_MORE_MASK) == TAG_MORE_MASK) ?
                     PH_TAG_MORE : PH_LEN_FIRST;
      end
      PH_TAG_MORE: begin
        if (tag_bytes_seen >= 3'(MAX_TAG_BYTES)) begin
          stop_status_next = STATUS_TAG_LONG;
          phase_next       = PH_STOPPED;
        end else begin
          tag_accum_next      = {tag_accum[23:0], byte_word.data_byte};
          tag_bytes_seen_next = tag_bytes_seen + 3'd1;
          if ((byte_word.data_byte & HIGH_BIT) == 8'd0) begin
            phase_next = PH_LEN_FIRST;
          end
        end
      end
      PH_LEN_FIRST: begin
        if ((byte_word.data_byte & HIGH_BIT) == 8'd0) begin
          header_len = {8'd0, byte_word.data_byte};
          has_item   = 1'b1;
        end else if (len_count == 7'd0 || len_count > 7'(MAX_LEN_BYTES)) begin
          stop_status_next = STATUS_BAD_LEN;
          phase_next       = PH_STOPPED;
        end else begin
          length_accum_next      = '0;
          length_bytes_left_next = len_count[1:0];
          phase_next             = PH_LEN_MORE;
        end
      end
      PH_LEN_MORE: begin
        length_accum_next = {length_accum[7:0], byte_word.data_byte};
        if (length_bytes_left > 2'd0) begin
          length_bytes_left_next = length_bytes_left - 2'd1;
        end
        if (length_bytes_left_next == 2'd0) begin
          header_len = length_accum_next;
          has_item   = 1'b1;
        end
      end
      PH_VALUE: begin
        if (value_bytes_left > 16'd0) begin
          value_bytes_left_next = value_bytes_left - 16'd1;
        end
        has_item               = 1'b1;
        item_word.result_kind  = KIND_VALUE;
        item_word.value_byte   = byte_word.data_byte;
        item_word.item_end     = (value_bytes_left_next == 16'd0);
      end
      default: begin
      end
    endcase

    // A header closes the length field; a zero length also ends the item.
    if (has_item && phase != PH_VALUE) begin
      length_accum_next      = header_len;
      item_word.result_kind  = KIND_HEADER;
      item_word.tag_value    = tag_accum_next;
      item_word.value_length = header_len;
      item_word.item_end     = (header_len == 16'd0);
      if (header_len != 16'd0) begin
        value_bytes_left_next = header_len;
        phase_next            = PH_VALUE;
      end
    end

    // Item completion clears the per-item fields and counts the item.
    if (has_item && item_word.item_end) begin
      if (items_parsed != COUNT_MAX) begin
        items_parsed_next = items_parsed + 15'd1;
      end
      tag_accum_next         = '0;
      tag_bytes_seen_next    = '0;
      length_accum_next      = '0;
      length_bytes_left_next = '0;
      value_bytes_left_next  = '0;
      phase_next             = PH_TAG_FIRST;
    end

    // The done report sees the state as this byte leaves it.
    done_status = stop_status_next;
    if (stop_status_next == STATUS_OK && phase_next != PH_TAG_FIRST) begin
      done_status = STATUS_TRUNCATED;
    end
    done_word              = '0;
    done_word.result_kind  = KIND_DONE;
    done_word.parse_status = done_status;
    done_word.item_count   = items_parsed_next;
    done_word.last_result  = 1'b1;

    if (byte_word.buffer_end) begin
      phase_next             = PH_TAG_FIRST;
      tag_accum_next         = '0;
      tag_bytes_seen_next    = '0;
      length_accum_next      = '0;
      length_bytes_left_next = '0;
      value_bytes_left_next  = '0;
      items_parsed_next      = '0;
      stop_status_next       = STATUS_OK;
    end

    item_word.last_result = !byte_word.buffer_end;

    // Order the words of this byte: the item result comes first.
    first_word  = has_item ? item_word : done_word;
    second_word = done_word;
    n_words     = 2'(has_item) + 2'(byte_word.buffer_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TAG_FIRST;
      tag_accum         <= '0;
      tag_bytes_seen    <= '0;
      length_accum      <= '0;
      length_bytes_left <= '0;
      value_bytes_left  <= '0;
      items_parsed      <= '0;
      stop_status       <= STATUS_OK;
    end else if (accept) begin
      phase             <= phase_next;
      tag_accum         <= tag_accum_next;
      tag_bytes_seen    <= tag_bytes_seen_next;
      length_accum      <= length_accum_next;
      length_bytes_left <= length_bytes_left_next;
      value_bytes_left  <= value_bytes_left_next;
      items_parsed      <= items_parsed_next;
      stop_status       <= stop_status_next;
    end
  end

  // Queue payload; the pointers and count below say which entries hold words.
  always_ff @(posedge clk) begin
    if (accept && n_words != 2'd0) begin
      queue[wr_ptr] <= first_word;
    end
    if (accept && n_words == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= second_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + QPTR_W'(n_words);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (accept ? (QPTR_W + 1)'(n_words) : (QPTR_W + 1)'(0))
                     - (pop ? (QPTR_W + 1)'(1) : (QPTR_W + 1)'(0));
    end
  end

endmodule
